FILE: hdl/dda_grid_ray_caster_unit_defines.svh
// Assertion macros for the ray caster RTL (used by the controller)
`ifndef DDA_GRID_RAY_CASTER_UNIT_DEFINES_SVH
`define DDA_GRID_RAY_CASTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define DGRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dgrc same-cycle check failed");

// Next-cycle implication, checked outside reset
`define DGRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dgrc next-cycle check failed");

`endif

FILE: hdl/dgrc_pkg.sv
// Package: constants, command and status types of the ray caster
`default_nettype none
package dgrc_pkg;

  localparam int MAP_SIDE  = 64;
  localparam int MAP_BITS  = $clog2(MAP_SIDE);
  localparam int MAP_DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int COORD_W   = MAP_BITS + 2;
  localparam int STEP_MAX  = 2 * MAP_SIDE + 3;
  localparam int STEP_W    = $clog2(STEP_MAX + 1);

  localparam int POS_W   = 22;
  localparam int VEC_W   = 18;
  localparam int SW_W    = 13;
  localparam int CODE_W  = 8;
  localparam int CELL_W  = 6;
  localparam int COL_W   = 12;
  localparam int DIST_W  = 24;
  localparam int CFG_W   = 22;
  localparam int IDX_W   = 3;
  localparam int IN_W    = 32;
  localparam int OUT_W   = 88;

  localparam int DIV_W   = 33;
  localparam int DELTA_W = 32;
  localparam int SIDE_W  = 41;
  localparam int RAY_W   = 32;
  localparam int MA_W    = 33;
  localparam int MB_W    = 25;
  localparam int MP_W    = MA_W + MB_W;

  typedef enum logic [IDX_W-1:0] {
    REG_POS_X, REG_POS_Y, REG_DIR_X, REG_DIR_Y,
    REG_PLANE_X, REG_PLANE_Y, REG_SCREEN_W, REG_WALL_CODE
  } reg_idx_t;

  typedef enum logic [1:0] { DIV_CAM, DIV_DX, DIV_DY } div_sel_t;

  typedef enum logic [2:0] {
    MUL_RX, MUL_RY, MUL_SX, MUL_SY, MUL_PX, MUL_PY
  } mul_sel_t;

  typedef enum logic [3:0] {
    LD_NONE, LD_CAM, LD_RX, LD_RY, LD_DX, LD_DY, LD_SDX, LD_SDY, LD_PX, LD_PY
  } ld_sel_t;

  typedef struct packed {
    logic     capture;
    logic     map_write;
    logic     div_start;
    div_sel_t div_sel;
    mul_sel_t mul_sel;
    ld_sel_t  ld;
    logic     dda_init;
    logic     map_read;
    logic     dda_step;
    logic     set_esc;
    logic     clr_esc;
    logic     load_out;
  } dgrc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic out_free;
    logic at_limit;
    logic off_grid;
    logic is_wall;
  } dgrc_sts_t;

endpackage
`default_nettype wire

FILE: hdl/dda_grid_ray_caster_unit.sv
// Top level: grid ray caster with DDA walk over a 64x64 byte map
//
// Input stream s_*: tuser[0] is the command (0 writes a map cell, 1 casts).
// A write stores one cell and gives no output word. A cast
// takes the screen column and returns one word on m_*.
// Config channel cfg_*: always ready; index 0..7 selects pos_x, pos_y,
// dir_x, dir_y, plane_x, plane_y, screen_width, wall_code. Write only while
// no cast is in flight.
// A cast runs in order: setup (three divisions through one shared restoring
// divider and four products on one shared multiplier), a walk over the
// grid cells with one map RAM read per cell checked, which ends at a wall
// cell or when the ray leaves the grid or reaches the step limit, then two
// more products for the hit point and the handoff to m_*.
// One cast is worked at a time; s_tready is high only between casts, so a
// new cast waits until the last result is loaded; writes may follow back to back.
// The result sits in an output register, so a stalled m_tready does not
// stop the next cast from being taken; only the handoff of that cast waits.
// Reset restores the documented register defaults and clears all control;
// map contents are undefined until written.
`default_nettype none
module dda_grid_ray_caster_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  // tdata: cell_x[5:0], cell_y[11:6], cell_value[19:12], column[31:20]
  input  wire logic [dgrc_pkg::IN_W-1:0]  s_tdata,
  // tuser: command[0]
  input  wire logic                       s_tuser,
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // tdata: perp_distance[23:0], hit_side[24], hit_cell_x[30:25],
  // hit_cell_y[36:31], hit_point_x[58:37], hit_point_y[80:59], escaped[81]
  output logic      [dgrc_pkg::OUT_W-1:0] m_tdata,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [dgrc_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [dgrc_pkg::CFG_W-1:0] cfg_data
);
  import dgrc_pkg::*;

  dgrc_cmd_t cmd;
  dgrc_sts_t sts;

  assign cfg_ready = 1'b1;

  // Sequencer
  dgrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .cast     (s_tuser),
    .s_tready (s_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Arithmetic, map and result
  dgrc_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cmd       (cmd),
    .sts       (sts)
  );
endmodule
`default_nettype wire

FILE: hdl/dgrc_ram.sv
// Generic single-port-write RAM with registered read
`default_nettype none
module dgrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: hdl/dgrc_ctrl.sv
// Controller: sequences ray setup, DDA walk and result handoff
`default_nettype none
`include "dda_grid_ray_caster_unit_defines.svh"
module dgrc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  input  wire logic                cast,
  output logic                     s_tready,
  output dgrc_pkg::dgrc_cmd_t      cmd,
  input  wire dgrc_pkg::dgrc_sts_t sts
);
  import dgrc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CAM_DIV, S_CAM_WAIT, S_MUL_RX, S_MUL_RY, S_RY_LD,
    S_DX_DIV, S_DX_WAIT, S_DY_DIV, S_DY_WAIT, S_MUL_SX, S_MUL_SY,
    S_SY_LD, S_CHK, S_RD, S_MUL_PX, S_MUL_PY, S_PY_LD, S_OUT
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.div_sel = DIV_CAM;
    cmd.mul_sel = MUL_RX;
    cmd.ld      = LD_NONE;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cast) begin
            cmd.capture = 1'b1;
            state_next  = S_CAM_DIV;
          end else begin
            cmd.map_write = 1'b1;
          end
        end
      end
      S_CAM_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_CAM;
        state_next    = S_CAM_WAIT;
      end
      S_CAM_WAIT: begin
        if (!sts.div_busy) begin
          cmd.ld     = LD_CAM;
          state_next = S_MUL_RX;
        end
      end
      S_MUL_RX: begin
        cmd.mul_sel = MUL_RX;
        state_next  = S_MUL_RY;
      end
      S_MUL_RY: begin
        cmd.mul_sel = MUL_RY;
        cmd.ld      = LD_RX;
        state_next  = S_RY_LD;
      end
      S_RY_LD: begin
        cmd.ld     = LD_RY;
        state_next = S_DX_DIV;
      end
      S_DX_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DX;
        state_next    = S_DX_WAIT;
      end
      S_DX_WAIT: begin
        if (!sts.div_busy) begin
          cmd.ld     = LD_DX;
          state_next = S_DY_DIV;
        end
      end
      S_DY_DIV: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_DY;
        state_next    = S_DY_WAIT;
      end
      S_DY_WAIT: begin
        if (!sts.div_busy) begin
          cmd.ld     = LD_DY;
          state_next = S_MUL_SX;
        end
      end
      S_MUL_SX: begin
        cmd.mul_sel = MUL_SX;
        state_next  = S_MUL_SY;
      end
      S_MUL_SY: begin
        cmd.mul_sel = MUL_SY;
        cmd.ld      = LD_SDX;
        state_next  = S_SY_LD;
      end
      S_SY_LD: begin
        cmd.ld       = LD_SDY;
        cmd.dda_init = 1'b1;
        state_next   = S_CHK;
      end
      // Walk: check bounds and step limit, then fetch the cell
      S_CHK: begin
        if (sts.at_limit || sts.off_grid) begin
          cmd.set_esc = 1'b1;
          state_next  = S_MUL_PX;
        end else begin
          cmd.map_read = 1'b1;
          state_next   = S_RD;
        end
      end
      S_RD: begin
        if (sts.is_wall) begin
          cmd.clr_esc = 1'b1;
          state_next  = S_MUL_PX;
        end else begin
          cmd.dda_step = 1'b1;
          state_next   = S_CHK;
        end
      end
      S_MUL_PX: begin
        cmd.mul_sel = MUL_PX;
        state_next  = S_MUL_PY;
      end
      S_MUL_PY: begin
        cmd.mul_sel = MUL_PY;
        cmd.ld      = LD_PX;
        state_next  = S_PY_LD;
      end
      S_PY_LD: begin
        cmd.ld     = LD_PY;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `DGRC_ASSERT_NEXT(a_cast_starts_div, accept && cast, state == S_CAM_DIV)
  `DGRC_ASSERT_NEXT(a_write_stays_idle, accept && !cast, state == S_IDLE)
  `DGRC_ASSERT_NOW(a_load_needs_room, cmd.load_out, sts.out_free)
endmodule
`default_nettype wire

FILE: hdl/dgrc_datapath.sv
// Datapath: config registers, divider, multiplier, DDA walk, map, result
`default_nettype none
module dgrc_datapath (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  input  wire logic [dgrc_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [dgrc_pkg::CFG_W-1:0]  cfg_data,
  input  wire logic [dgrc_pkg::IN_W-1:0]   s_tdata,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic      [dgrc_pkg::OUT_W-1:0]  m_tdata,
  input  wire dgrc_pkg::dgrc_cmd_t         cmd,
  output dgrc_pkg::dgrc_sts_t              sts
);
  import dgrc_pkg::*;

  // Configuration
  logic        [POS_W-1:0]  pos_x, pos_y;
  logic signed [VEC_W-1:0]  dir_x, dir_y, plane_x, plane_y;
  logic        [SW_W-1:0]   screen_w;
  logic        [CODE_W-1:0] wall_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= '0;
      pos_y     <= '0;
      dir_x     <= VEC_W'(65536);
      dir_y     <= '0;
      plane_x   <= '0;
      plane_y   <= VEC_W'(43254);
      screen_w  <= SW_W'(640);
      wall_code <= CODE_W'(49);
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_POS_X:     pos_x     <= cfg_data[POS_W-1:0];
        REG_POS_Y:     pos_y     <= cfg_data[POS_W-1:0];
        REG_DIR_X:     dir_x     <= cfg_data[VEC_W-1:0];
        REG_DIR_Y:     dir_y     <= cfg_data[VEC_W-1:0];
        REG_PLANE_X:   plane_x   <= cfg_data[VEC_W-1:0];
        REG_PLANE_Y:   plane_y   <= cfg_data[VEC_W-1:0];
        REG_SCREEN_W:  screen_w  <= cfg_data[SW_W-1:0];
        REG_WALL_CODE: wall_code <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Working registers
  logic        [COL_W-1:0]   column;
  logic signed [MA_W-1:0]    cam;
  logic signed [RAY_W-1:0]   rx, ry;
  logic        [DELTA_W-1:0] dx, dy;
  logic        [SIDE_W-1:0]  sdx, sdy, perp;
  logic signed [COORD_W-1:0] mx, my;
  logic        [STEP_W-1:0]  n;
  logic                      side, esc;
  logic        [POS_W-1:0]   px, py;

  // Restoring divider, one quotient bit per cycle
  logic [DIV_W-1:0] div_q, div_d;
  logic [DIV_W:0]   div_r, div_sh;
  logic [5:0]       div_cnt;
  logic [DIV_W-1:0] start_num, start_den;
  logic [SW_W-1:0]  sw_eff;
  logic [RAY_W-1:0] abs_rx, abs_ry;

  assign sw_eff = (screen_w == '0) ? SW_W'(1) : screen_w;
  assign abs_rx = rx[RAY_W-1] ? RAY_W'(-rx) : RAY_W'(rx);
  assign abs_ry = ry[RAY_W-1] ? RAY_W'(-ry) : RAY_W'(ry);
  assign div_sh = {div_r[DIV_W-1:0], div_q[DIV_W-1]};

  always_comb begin
    unique case (cmd.div_sel)
      DIV_CAM: begin
        start_num = DIV_W'({column, 17'b0});
        start_den = DIV_W'(sw_eff);
      end
      DIV_DX: begin
        start_num = DIV_W'(1) << DELTA_W;
        start_den = DIV_W'(abs_rx);
      end
      DIV_DY: begin
        start_num = DIV_W'(1) << DELTA_W;
        start_den = DIV_W'(abs_ry);
      end
      default: begin
        start_num = '0;
        start_den = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_start) begin
      div_cnt <= 6'(DIV_W);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_q <= start_num;
      div_d <= start_den;
      div_r <= '0;
    end else if (div_cnt != '0) begin
      if (div_sh >= {1'b0, div_d}) begin
        div_r <= div_sh - {1'b0, div_d};
        div_q <= {div_q[DIV_W-2:0], 1'b1};
      end else begin
        div_r <= div_sh;
        div_q <= {div_q[DIV_W-2:0], 1'b0};
      end
    end
  end

  // Shared multiplier, product registered
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] mul_p;
  logic        [16:0]     frac_x, frac_y;
  logic        [DIST_W-1:0] dist_sat;

  assign frac_x = rx[RAY_W-1] ? {1'b0, pos_x[15:0]} : 17'h10000 - {1'b0, pos_x[15:0]};
  assign frac_y = ry[RAY_W-1] ? {1'b0, pos_y[15:0]} : 17'h10000 - {1'b0, pos_y[15:0]};
  assign dist_sat = (perp > SIDE_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : perp[DIST_W-1:0];

  always_comb begin
    unique case (cmd.mul_sel)
      MUL_RX: begin mul_a = cam; mul_b = MB_W'(plane_x); end
      MUL_RY: begin mul_a = cam; mul_b = MB_W'(plane_y); end
      MUL_SX: begin mul_a = MA_W'({1'b0, dx}); mul_b = MB_W'({1'b0, frac_x}); end
      MUL_SY: begin mul_a = MA_W'({1'b0, dy}); mul_b = MB_W'({1'b0, frac_y}); end
      MUL_PX: begin mul_a = MA_W'(rx); mul_b = MB_W'({1'b0, dist_sat}); end
      MUL_PY: begin mul_a = MA_W'(ry); mul_b = MB_W'({1'b0, dist_sat}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  // Post-multiply terms: floor(p / 2^16) and clamped hit coordinate
  logic signed [MP_W-17:0] p_q16;
  logic signed [MP_W-16:0] pt_sum;
  logic        [POS_W-1:0] pt_base, pt_clamp;
  logic        [DELTA_W-1:0] q_sat;

  assign p_q16   = mul_p[MP_W-1:16];
  assign pt_base = (cmd.ld == LD_PY) ? pos_y : pos_x;
  assign pt_sum  = $signed({{(MP_W-15-POS_W){1'b0}}, pt_base}) + (MP_W-15)'(p_q16);
  assign q_sat   = div_q[DELTA_W] ? {DELTA_W{1'b1}} : div_q[DELTA_W-1:0];

  always_comb begin
    if (pt_sum[MP_W-16]) begin
      pt_clamp = '0;
    end else if (pt_sum > (MP_W-15)'({POS_W{1'b1}})) begin
      pt_clamp = {POS_W{1'b1}};
    end else begin
      pt_clamp = pt_sum[POS_W-1:0];
    end
  end

  // Register loads
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      column <= s_tdata[31:20];
    end
    unique case (cmd.ld)
      LD_CAM: cam <= MA_W'(div_q) - MA_W'(65536);
      LD_RX:  rx  <= RAY_W'(p_q16) + RAY_W'(dir_x);
      LD_RY:  ry  <= RAY_W'(p_q16) + RAY_W'(dir_y);
      LD_DX:  dx  <= q_sat;
      LD_DY:  dy  <= q_sat;
      LD_SDX: sdx <= SIDE_W'(mul_p[48:16]);
      LD_SDY: sdy <= SIDE_W'(mul_p[48:16]);
      LD_PX:  px  <= pt_clamp;
      LD_PY:  py  <= pt_clamp;
      default: ;
    endcase
    // DDA walk
    if (cmd.dda_init) begin
      mx   <= COORD_W'(pos_x[POS_W-1:16]);
      my   <= COORD_W'(pos_y[POS_W-1:16]);
      n    <= '0;
      perp <= '0;
      side <= 1'b0;
    end else if (cmd.dda_step) begin
      n <= n + STEP_W'(1);
      if (sdx < sdy) begin
        perp <= sdx;
        sdx  <= sdx + SIDE_W'(dx);
        mx   <= rx[RAY_W-1] ? mx - COORD_W'(1) : mx + COORD_W'(1);
        side <= 1'b0;
      end else begin
        perp <= sdy;
        sdy  <= sdy + SIDE_W'(dy);
        my   <= ry[RAY_W-1] ? my - COORD_W'(1) : my + COORD_W'(1);
        side <= 1'b1;
      end
    end
    if (cmd.set_esc) begin
      esc <= 1'b1;
    end else if (cmd.clr_esc) begin
      esc <= 1'b0;
    end
  end

  // Map store
  logic [CODE_W-1:0] cell_rd;

  dgrc_ram #(.WIDTH(CODE_W), .DEPTH(MAP_DEPTH)) u_map (
    .clk   (clk),
    .we    (cmd.map_write),
    .waddr ({s_tdata[11:6], s_tdata[5:0]}),
    .wdata (s_tdata[19:12]),
    .re    (cmd.map_read),
    .raddr ({my[MAP_BITS-1:0], mx[MAP_BITS-1:0]}),
    .rdata (cell_rd)
  );

  // Result register
  logic [CELL_W-1:0] hcx, hcy;

  assign hcx = esc ? '0 : CELL_W'(mx[MAP_BITS-1:0]);
  assign hcy = esc ? '0 : CELL_W'(my[MAP_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {6'b0, esc, py, px, hcy, hcx, side, dist_sat};
    end
  end

  // Status to the controller
  assign sts.div_busy = (div_cnt != '0);
  assign sts.out_free = !m_tvalid || m_tready;
  assign sts.at_limit = (n == STEP_W'(STEP_MAX));
  assign sts.off_grid = mx[COORD_W-1] || my[COORD_W-1] ||
                        (mx >= COORD_W'(MAP_SIDE)) || (my >= COORD_W'(MAP_SIDE));
  assign sts.is_wall  = (cell_rd == wall_code);
endmodule
`default_nettype wire
